// File: rtl/calu_pkg.sv
// Package for the eight-bit CPU arithmetic unit: operation codes, flag bit
// positions and the constants used by decimal adjust.
// No dependencies.
`default_nettype none

package calu_pkg;

    localparam int KIND_W = 5;
    localparam int WORD_W = 16;
    localparam int BYTE_W = 8;
    localparam int FLAG_W = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD     = 5'd0,
        KIND_ADC     = 5'd1,
        KIND_SUB     = 5'd2,
        KIND_SBC     = 5'd3,
        KIND_AND     = 5'd4,
        KIND_OR      = 5'd5,
        KIND_XOR     = 5'd6,
        KIND_CP      = 5'd7,
        KIND_INC8    = 5'd8,
        KIND_DEC8    = 5'd9,
        KIND_RLCA    = 5'd10,
        KIND_RLA     = 5'd11,
        KIND_RRCA    = 5'd12,
        KIND_RRA     = 5'd13,
        KIND_DAA     = 5'd14,
        KIND_SCF     = 5'd15,
        KIND_CPL     = 5'd16,
        KIND_CCF     = 5'd17,
        KIND_ADD16   = 5'd18,
        KIND_SP_OFS  = 5'd19,
        KIND_INC16   = 5'd20,
        KIND_DEC16   = 5'd21
    } kind_t;

    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    localparam logic [BYTE_W-1:0] DAA_LOW_FIX  = 8'h06;
    localparam logic [BYTE_W-1:0] DAA_HIGH_FIX = 8'h60;
    localparam logic [BYTE_W-1:0] DAA_LIMIT    = 8'h99;
    localparam logic [3:0]        BCD_MAX      = 4'h9;

endpackage

`default_nettype wire

// File: rtl/cpu_alu_with_flags_top.sv
// Top level of the eight-bit CPU arithmetic unit with Z/N/H/C flags.
// Depends on calu_pkg.
`default_nettype none

// The unit takes one beat per clock while s_axis_tready is high and returns
// one result beat for each input beat, after it has passed the input register
// and then the result register; each holds one beat, and all arithmetic is
// done in one pass of combinational logic between them. With the output side
// always ready the sustained rate is one beat per cycle; a stalled output fills
// both registers and then holds the input side off.
module cpu_alu_with_flags_top
    import calu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // Fields from bit 0: operand_a[15:0], operand_b[31:16], flags_in[35:32], zero pad.
    input  wire logic [39:0] s_axis_tdata,
    // Fields from bit 0: kind[4:0].
    input  wire logic [4:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // Fields from bit 0: result_value[15:0], flags_out[19:16], zero pad.
    output logic [23:0]      m_axis_tdata
);

    logic                  in_valid_reg;
    logic [KIND_W-1:0]     kind_reg;
    logic [WORD_W-1:0]     opa_reg;
    logic [WORD_W-1:0]     opb_reg;
    logic [FLAG_W-1:0]     fin_reg;

    logic                  out_valid_reg;
    logic [WORD_W-1:0]     result_reg;
    logic [FLAG_W-1:0]     flags_reg;

    logic                  out_load;
    logic                  in_load;
    logic [WORD_W-1:0]     result_next;
    logic [FLAG_W-1:0]     flags_next;

    assign out_load      = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                in_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            kind_reg <= s_axis_tuser;
            opa_reg  <= s_axis_tdata[15:0];
            opb_reg  <= s_axis_tdata[31:16];
            fin_reg  <= s_axis_tdata[35:32];
        end
        if (out_load)
        begin
            result_reg <= result_next;
            flags_reg  <= flags_next;
        end
    end

    logic [BYTE_W-1:0]   a8;
    logic [BYTE_W-1:0]   b8;
    logic                cin;
    logic                use_carry;
    logic [BYTE_W:0]     add9;
    logic [4:0]          add_half;
    logic [BYTE_W:0]     sub9;
    logic [4:0]          sub_half;
    logic [BYTE_W-1:0]   logic8;
    logic [BYTE_W-1:0]   inc8;
    logic [BYTE_W-1:0]   dec8;
    logic                daa_hi;
    logic                daa_lo;
    logic [BYTE_W-1:0]   daa_fix;
    logic [BYTE_W-1:0]   daa8;
    logic [WORD_W:0]     add17;
    logic [12:0]         add_half16;
    logic [WORD_W-1:0]   ofs16;
    logic [BYTE_W-1:0]   r8;

    assign a8        = opa_reg[7:0];
    assign b8        = opb_reg[7:0];
    assign cin       = fin_reg[FLAG_C];
    assign use_carry = ((kind_reg == KIND_ADC) || (kind_reg == KIND_SBC)) && cin;

    assign add9     = {1'b0, a8} + {1'b0, b8} + {8'd0, use_carry};
    assign add_half = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, use_carry};
    assign sub9     = {1'b0, a8} - {1'b0, b8} - {8'd0, use_carry};
    assign sub_half = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, use_carry};
    assign inc8     = a8 + 8'd1;
    assign dec8     = a8 - 8'd1;

    assign daa_hi  = fin_reg[FLAG_N] ? cin : (cin || (a8 > DAA_LIMIT));
    assign daa_lo  = fin_reg[FLAG_N] ? fin_reg[FLAG_H]
                                     : (fin_reg[FLAG_H] || (a8[3:0] > BCD_MAX));
    assign daa_fix = (daa_hi ? DAA_HIGH_FIX : 8'h00) | (daa_lo ? DAA_LOW_FIX : 8'h00);
    assign daa8    = fin_reg[FLAG_N] ? (a8 - daa_fix) : (a8 + daa_fix);

    assign add17      = {1'b0, opa_reg} + {1'b0, opb_reg};
    assign add_half16 = {1'b0, opa_reg[11:0]} + {1'b0, opb_reg[11:0]};
    assign ofs16      = opa_reg + {{BYTE_W{b8[7]}}, b8};

    always_comb
    begin
        case (kind_reg)
            KIND_AND: logic8 = a8 & b8;
            KIND_OR:  logic8 = a8 | b8;
            default:  logic8 = a8 ^ b8;
        endcase
    end

    always_comb
    begin
        result_next = opa_reg;
        flags_next  = fin_reg;
        r8          = 8'h00;
        case (kind_reg)
            KIND_ADD, KIND_ADC:
            begin
                r8          = add9[7:0];
                result_next = {8'h00, r8};
                flags_next  = {r8 == 8'h00, 1'b0, add_half[4], add9[8]};
            end
            KIND_SUB, KIND_SBC, KIND_CP:
            begin
                r8          = sub9[7:0];
                result_next = (kind_reg == KIND_CP) ? {8'h00, a8} : {8'h00, r8};
                flags_next  = {r8 == 8'h00, 1'b1, sub_half[4], sub9[8]};
            end
            KIND_AND, KIND_OR, KIND_XOR:
            begin
                r8          = logic8;
                result_next = {8'h00, r8};
                flags_next  = {r8 == 8'h00, 1'b0, kind_reg == KIND_AND, 1'b0};
            end
            KIND_INC8:
            begin
                r8          = inc8;
                result_next = {8'h00, r8};
                flags_next  = {r8 == 8'h00, 1'b0, a8[3:0] == 4'hF, cin};
            end
            KIND_DEC8:
            begin
                r8          = dec8;
                result_next = {8'h00, r8};
                flags_next  = {r8 == 8'h00, 1'b1, a8[3:0] == 4'h0, cin};
            end
            KIND_RLCA:
            begin
                result_next = {8'h00, a8[6:0], a8[7]};
                flags_next  = {3'b000, a8[7]};
            end
            KIND_RLA:
            begin
                result_next = {8'h00, a8[6:0], cin};
                flags_next  = {3'b000, a8[7]};
            end
            KIND_RRCA:
            begin
                result_next = {8'h00, a8[0], a8[7:1]};
                flags_next  = {3'b000, a8[0]};
            end
            KIND_RRA:
            begin
                result_next = {8'h00, cin, a8[7:1]};
                flags_next  = {3'b000, a8[0]};
            end
            KIND_DAA:
            begin
                r8          = daa8;
                result_next = {8'h00, r8};
                flags_next  = {r8 == 8'h00, fin_reg[FLAG_N], 1'b0,
                               fin_reg[FLAG_N] ? cin : (cin || daa_hi)};
            end
            KIND_SCF:
            begin
                result_next = {8'h00, a8};
                flags_next  = {fin_reg[FLAG_Z], 3'b001};
            end
            KIND_CPL:
            begin
                result_next = {8'h00, ~a8};
                flags_next  = {fin_reg[FLAG_Z], 2'b11, cin};
            end
            KIND_CCF:
            begin
                result_next = {8'h00, a8};
                flags_next  = {fin_reg[FLAG_Z], 2'b00, !cin};
            end
            KIND_ADD16:
            begin
                result_next = add17[15:0];
                flags_next  = {fin_reg[FLAG_Z], 1'b0, add_half16[12], add17[16]};
            end
            KIND_SP_OFS:
            begin
                result_next = ofs16;
                flags_next  = {2'b00, add_half[4], add9[8]};
            end
            KIND_INC16:
            begin
                result_next = opa_reg + 16'd1;
            end
            KIND_DEC16:
            begin
                result_next = opa_reg - 16'd1;
            end
            default:
            begin
                result_next = opa_reg;
                flags_next  = fin_reg;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'h0, flags_reg, result_reg};

`ifndef SYNTHESIS
    a_result_held_on_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg && $stable(result_reg)
            && $stable(flags_reg))
        else $error("result beat changed or dropped while stalled");

    a_no_accept_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("input beat accepted with both registers full");

    a_input_moves_forward: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_valid_reg && (!out_valid_reg || m_axis_tready) |=> out_valid_reg)
        else $error("held input beat did not reach the result register");

    a_input_kept_on_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_load |=> in_valid_reg && $stable(kind_reg)
            && $stable(opa_reg))
        else $error("input register lost a beat while blocked");
`endif

endmodule

`default_nettype wire
